// ===== rtl/core/memory_region_table_core_defines.svh =====
// Assertion macros for the port-level checker of the region table.
`ifndef MEMORY_REGION_TABLE_CORE_DEFINES_SVH
`define MEMORY_REGION_TABLE_CORE_DEFINES_SVH
// Implication checked at every clock edge outside reset.
`define MRT_ASSERT_IMPL(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define MRT_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");
`endif

// ===== rtl/core/mrt_pkg.sv =====
// Package with the item types, codes and state encoding of the region table.
package mrt_pkg;
   localparam int unsigned FLAG_READ  = 0;
   localparam int unsigned FLAG_WRITE = 1;
   localparam int unsigned FLAG_STACK = 3;

   typedef enum logic [1:0] {
      KIND_MAP   = 2'd0,
      KIND_FIND  = 2'd1,
      KIND_CHECK = 2'd2,
      KIND_CLEAR = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_FULL    = 2'd2
   } status_type;

   typedef enum logic [0:0] {
      REG_USER_BASE = 1'd0,
      REG_USER_TOP  = 1'd1
   } reg_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] address;
      logic [31:0] length;
      logic [3:0]  flags;
      logic        write_access;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        allowed;
      logic        found;
      logic [31:0] found_start;
      logic [31:0] found_end;
      logic [3:0]  found_flags;
      logic [4:0]  region_total;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LH_RD,
      ST_LH_CMP,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_MAP_RD,
      ST_MAP_CMP,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_INSERT,
      ST_RESP
   } state_type;
endpackage

// ===== rtl/core/mrt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mrt_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/core/memory_region_table_core.sv =====
// Top level of the region table: sequencer, shared comparator and table RAM.
//
// Usage: items arrive on the req_ channel (valid/stall) and each item gives
// exactly one result item on the rsp_ channel. The block works on one item at
// a time: req_stall is high from acceptance until the result has been loaded
// into the output register. The output register frees the sequencer, so a new
// item can be accepted while a result still waits under rsp_stall.
// Sequence: clear goes straight to the result. A find probes the last-hit
// entry and then scans the table entry by entry. A map scans every held
// entry for overlap and moves the entries at and above the insert point.
// A check repeats the find walk for every region it crosses, with the
// rescans going through the single read port of the table RAM.
// Configuration: user_base at byte address 0, user_top at 4, written through
// the APB-style p-prefixed port; reads return the value. The user must write
// them only while the block is idle; the block itself does not enforce it.
// Reset clears the region count and the last-hit index; the table RAM needs no
// clearing pass because entries at and above the count are never read.
// When the receiver stalls, the result holds in the output register.
module memory_region_table_core #(
   parameter int unsigned MAX_REGIONS = 16,
   parameter int unsigned PAGE_BITS   = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  mrt_pkg::req_type     req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output mrt_pkg::rsp_type     rsp_data,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [2:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);
   localparam int unsigned IW = $clog2(MAX_REGIONS);
   localparam int unsigned CW = $clog2(MAX_REGIONS + 1);
   localparam int unsigned EW = 68;

   // Configuration registers.
   logic [31:0] user_base_ff, user_top_ff;
   logic        csr_wr;
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;
   always_ff @(posedge clock) begin
      if (reset) begin
         user_base_ff <= 32'h0020_0000;
         user_top_ff  <= 32'hB000_0000;
      end else if (csr_wr) begin
         if (paddr[2] == mrt_pkg::REG_USER_BASE) begin
            user_base_ff <= pwdata;
         end else begin
            user_top_ff <= pwdata;
         end
      end
   end
   assign prdata = (paddr[2] == mrt_pkg::REG_USER_BASE) ? user_base_ff : user_top_ff;

   // Control registers.
   mrt_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] lh_ff, lh_in;
   logic          lhv_ff, lhv_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [CW-1:0] steps_ff, steps_in;
   logic          out_v_ff, out_v_in;

   // Payload registers of the item at work.
   mrt_pkg::req_type req_ff, req_in;
   logic [32:0] cur_ff, cur_in;
   logic [32:0] e_ff, e_in;
   logic [32:0] s_ff, s_in;
   mrt_pkg::rsp_type res_ff, res_in;
   mrt_pkg::rsp_type out_ff, out_in;
   logic [CW-1:0] pos_ff, pos_in;

   // Table RAM: one entry holds start, end and flags.
   logic          wr_en;
   logic [IW-1:0] wr_addr, rd_addr;
   logic [EW-1:0] wr_data, rd_data;
   mrt_ram #(.WIDTH(EW), .DEPTH(MAX_REGIONS)) u_table (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );
   logic [31:0] e_start, e_end;
   logic [3:0]  e_flags;
   assign e_start = rd_data[67:36];
   assign e_end   = rd_data[35:4];
   assign e_flags = rd_data[3:0];

   // Shared compare unit: containment of the probe address in an entry.
   logic hit;
   mrt_cmp u_cmp (
      .probe(cur_ff), .lo({1'b0, e_start}), .hi({1'b0, e_end}), .inside_hit(hit)
   );

   // Map rounding and the window tests of map and check.
   logic [33:0] sum_w;
   logic [32:0] ms, me, ce;
   logic        map_ok, chk_ok;
   always_comb begin
      sum_w = {2'b0, req_data.address} + {2'b0, req_data.length}
            + 34'((1 << PAGE_BITS) - 1);
      ms = {1'b0, req_data.address} & ~33'((1 << PAGE_BITS) - 1);
      me = sum_w[32:0] & ~33'((1 << PAGE_BITS) - 1);
      ce = {1'b0, req_data.address} + {1'b0, req_data.length};
      map_ok = ms >= {1'b0, user_base_ff} && ms < me && me <= {1'b0, user_top_ff};
      chk_ok = {1'b0, req_data.address} >= {1'b0, user_base_ff}
            && {1'b0, req_data.address} < ce && ce <= {1'b0, user_top_ff};
   end

   logic accept, need_ok, stack_bad, lh_try;
   assign req_stall = (state_ff != mrt_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;
   assign need_ok   = req_ff.write_access ? e_flags[mrt_pkg::FLAG_WRITE]
                                          : e_flags[mrt_pkg::FLAG_READ];
   assign stack_bad = req_ff.write_access && e_flags[mrt_pkg::FLAG_STACK]
                   && cur_ff < ({1'b0, e_start} + 33'(1 << PAGE_BITS));
   assign lh_try    = lhv_ff && ({1'b0, lh_ff} < count_ff);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      lh_in = lh_ff;
      lhv_in = lhv_ff;
      idx_in = idx_ff;
      steps_in = steps_ff;
      req_in = req_ff;
      cur_in = cur_ff;
      e_in = e_ff;
      s_in = s_ff;
      res_in = res_ff;
      pos_in = pos_ff;
      out_in = out_ff;
      out_v_in = out_v_ff && rsp_stall;
      wr_en = 1'b0;
      wr_addr = idx_ff;
      wr_data = rd_data;
      rd_addr = idx_ff;
      unique case (state_ff)
         mrt_pkg::ST_IDLE: begin
            if (accept) begin
               req_in = req_data;
               res_in = '0;
               cur_in = {1'b0, req_data.address};
               steps_in = '0;
               idx_in = '0;
               unique case (mrt_pkg::kind_type'(req_data.kind))
                  mrt_pkg::KIND_MAP: begin
                     s_in = ms;
                     e_in = me;
                     pos_in = '0;
                     if (!map_ok) begin
                        res_in.status = mrt_pkg::STATUS_INVALID;
                        state_in = mrt_pkg::ST_RESP;
                     end else if (count_ff == '0) begin
                        state_in = mrt_pkg::ST_INSERT;
                     end else begin
                        state_in = mrt_pkg::ST_MAP_RD;
                     end
                  end
                  mrt_pkg::KIND_FIND: begin
                     state_in = mrt_pkg::ST_LH_RD;
                  end
                  mrt_pkg::KIND_CHECK: begin
                     e_in = ce;
                     if (!chk_ok) begin
                        state_in = mrt_pkg::ST_RESP;
                     end else begin
                        state_in = mrt_pkg::ST_LH_RD;
                     end
                  end
                  default: begin
                     count_in = '0;
                     lh_in = '0;
                     lhv_in = 1'b0;
                     state_in = mrt_pkg::ST_RESP;
                  end
               endcase
            end
         end
         mrt_pkg::ST_LH_RD: begin
            // Check step guard, then probe the last-hit entry first.
            if (req_ff.kind == mrt_pkg::KIND_CHECK && steps_ff > CW'(MAX_REGIONS)) begin
               state_in = mrt_pkg::ST_RESP;
            end else begin
               rd_addr = lh_ff;
               idx_in = '0;
               state_in = lh_try ? mrt_pkg::ST_LH_CMP : mrt_pkg::ST_SCAN_RD;
            end
         end
         mrt_pkg::ST_LH_CMP, mrt_pkg::ST_SCAN_CMP: begin
            if (hit) begin
               if (state_ff == mrt_pkg::ST_SCAN_CMP) begin
                  lh_in = idx_ff;
                  lhv_in = 1'b1;
               end
               if (req_ff.kind == mrt_pkg::KIND_FIND) begin
                  res_in.found = 1'b1;
                  res_in.found_start = e_start;
                  res_in.found_end = e_end;
                  res_in.found_flags = e_flags;
                  state_in = mrt_pkg::ST_RESP;
               end else if (!need_ok || stack_bad) begin
                  state_in = mrt_pkg::ST_RESP;
               end else if ({1'b0, e_end} >= e_ff) begin
                  res_in.allowed = 1'b1;
                  state_in = mrt_pkg::ST_RESP;
               end else begin
                  cur_in = {1'b0, e_end};
                  steps_in = steps_ff + 1'b1;
                  state_in = mrt_pkg::ST_LH_RD;
               end
            end else if (state_ff == mrt_pkg::ST_LH_CMP) begin
               idx_in = '0;
               state_in = mrt_pkg::ST_SCAN_RD;
            end else if ({1'b0, idx_ff} + 1'b1 >= count_ff) begin
               state_in = mrt_pkg::ST_RESP;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = mrt_pkg::ST_SCAN_RD;
            end
         end
         mrt_pkg::ST_SCAN_RD: begin
            rd_addr = idx_ff;
            state_in = (count_ff == '0) ? mrt_pkg::ST_RESP : mrt_pkg::ST_SCAN_CMP;
         end
         mrt_pkg::ST_MAP_RD: begin
            rd_addr = idx_ff;
            state_in = mrt_pkg::ST_MAP_CMP;
         end
         mrt_pkg::ST_MAP_CMP: begin
            // Overlap test and sorted position in one pass.
            if ({1'b0, e_start} < e_ff && s_ff < {1'b0, e_end}) begin
               res_in.status = mrt_pkg::STATUS_INVALID;
               state_in = mrt_pkg::ST_RESP;
            end else begin
               if ({1'b0, e_start} <= s_ff) begin
                  pos_in = CW'(idx_ff) + 1'b1;
               end
               if ({1'b0, idx_ff} + 1'b1 >= count_ff) begin
                  if (count_ff >= CW'(MAX_REGIONS)) begin
                     res_in.status = mrt_pkg::STATUS_FULL;
                     state_in = mrt_pkg::ST_RESP;
                  end else begin
                     idx_in = IW'(count_ff - 1'b1);
                     state_in = mrt_pkg::ST_SHIFT_RD;
                  end
               end else begin
                  idx_in = idx_ff + 1'b1;
                  state_in = mrt_pkg::ST_MAP_RD;
               end
            end
         end
         mrt_pkg::ST_SHIFT_RD: begin
            if (CW'(idx_ff) + 1'b1 <= pos_ff) begin
               state_in = mrt_pkg::ST_INSERT;
            end else begin
               rd_addr = idx_ff;
               state_in = mrt_pkg::ST_SHIFT_WR;
            end
         end
         mrt_pkg::ST_SHIFT_WR: begin
            wr_en = 1'b1;
            wr_addr = idx_ff + 1'b1;
            if (idx_ff == '0) begin
               state_in = mrt_pkg::ST_INSERT;
            end else begin
               idx_in = idx_ff - 1'b1;
               state_in = mrt_pkg::ST_SHIFT_RD;
            end
         end
         mrt_pkg::ST_INSERT: begin
            wr_en = 1'b1;
            wr_addr = IW'(pos_ff);
            wr_data = {s_ff[31:0], e_ff[31:0], req_ff.flags};
            if (lhv_ff && CW'(lh_ff) >= pos_ff) begin
               lh_in = lh_ff + 1'b1;
            end
            count_in = count_ff + 1'b1;
            res_in.found = 1'b1;
            res_in.found_start = s_ff[31:0];
            res_in.found_end = e_ff[31:0];
            res_in.found_flags = req_ff.flags;
            state_in = mrt_pkg::ST_RESP;
         end
         mrt_pkg::ST_RESP: begin
            if (!out_v_ff || !rsp_stall) begin
               out_in = res_ff;
               out_in.region_total = 5'(count_ff);
               out_v_in = 1'b1;
               state_in = mrt_pkg::ST_IDLE;
            end
         end
         default: state_in = mrt_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mrt_pkg::ST_IDLE;
         count_ff <= '0;
         lh_ff <= '0;
         lhv_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         lh_ff <= lh_in;
         lhv_ff <= lhv_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      steps_ff <= steps_in;
      req_ff <= req_in;
      cur_ff <= cur_in;
      e_ff <= e_in;
      s_ff <= s_in;
      res_ff <= res_in;
      pos_ff <= pos_in;
      out_ff <= out_in;
   end
endmodule

// ===== rtl/core/mrt_cmp.sv =====
// Shared compare unit: tests whether a probe address lies in [lo, hi).
module mrt_cmp (
   input  logic [32:0] probe,
   input  logic [32:0] lo,
   input  logic [32:0] hi,
   output logic        inside_hit
);
   assign inside_hit = (lo <= probe) && (probe < hi);
endmodule

// ===== rtl/core/memory_region_table_core_checker.sv =====
// Port-level checker for the region table, bound to the top level.
`include "memory_region_table_core_defines.svh"
module memory_region_table_core_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input mrt_pkg::rsp_type rsp_data
);
   `MRT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `MRT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `MRT_ASSERT_IMPL(a_total_range, clock, reset, rsp_valid, rsp_data.region_total <= 5'd16)
   `MRT_ASSERT_IMPL(a_status_code, clock, reset, rsp_valid, rsp_data.status != 2'd3)
endmodule

bind memory_region_table_core memory_region_table_core_checker u_checker (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .rsp_data
);

// ===== bench/memory_region_table_checker.sv =====
// Result checker for the region table: predicts every item and compares results.
module memory_region_table_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  mrt_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  mrt_pkg::rsp_type rsp_data,
   input  logic             cfg_write,
   input  logic [2:0]       cfg_addr,
   input  logic [31:0]      cfg_wdata,
   output int               fail_count,
   output int               pending_count
);
   import mrt_pkg::*;

   localparam int unsigned REGIONS = 16;
   localparam int unsigned PAGE_SHIFT = 12;
   localparam logic [63:0] PAGE = 64'd1 << PAGE_SHIFT;

   logic [31:0] window_base;
   logic [31:0] window_top;
   logic [31:0] region_start [REGIONS];
   logic [31:0] region_end [REGIONS];
   logic [3:0]  region_perm [REGIONS];
   int unsigned region_count;
   int unsigned hit_index;
   bit          hit_valid;
   rsp_type     expected_results[$];

   assign pending_count = expected_results.size();

   function automatic bit window_ok(logic [63:0] s, logic [63:0] e);
      return s >= {32'd0, window_base} && s < e && e <= {32'd0, window_top};
   endfunction

   function automatic int region_lookup(logic [63:0] a);
      if (hit_valid && hit_index < region_count && region_start[hit_index] <= a &&
          a < region_end[hit_index])
         return hit_index;
      for (int i = 0; i < region_count; i++) begin
         if (region_start[i] <= a && a < region_end[i]) begin
            hit_index = i;
            hit_valid = 1;
            return i;
         end
      end
      return -1;
   endfunction

   function automatic bit range_allowed(logic [63:0] a, logic [63:0] len, bit wr);
      logic [63:0] cur;
      logic [63:0] e;
      int idx;
      cur = a;
      e = a + len;
      if (!window_ok(a, e)) return 0;
      for (int steps = 0; cur < e; steps++) begin
         if (steps > REGIONS) return 0;
         idx = region_lookup(cur);
         if (idx < 0) return 0;
         if (wr ? !region_perm[idx][FLAG_WRITE] : !region_perm[idx][FLAG_READ]) return 0;
         if (wr && region_perm[idx][FLAG_STACK] && cur < {32'd0, region_start[idx]} + PAGE)
            return 0;
         cur = {32'd0, region_end[idx]};
      end
      return 1;
   endfunction

   function automatic rsp_type predict_item(req_type r);
      rsp_type o;
      logic [63:0] s;
      logic [63:0] e;
      int pos;
      int idx;
      bit clash;
      o = '0;
      case (kind_type'(r.kind))
         KIND_MAP: begin
            s = {32'd0, r.address} & ~(PAGE - 1);
            e = ({32'd0, r.address} + {32'd0, r.length} + PAGE - 1) & ~(PAGE - 1);
            clash = 0;
            for (int i = 0; i < region_count; i++)
               if (region_start[i] < e && s < region_end[i]) clash = 1;
            if (!window_ok(s, e) || clash) o.status = STATUS_INVALID;
            else if (region_count >= REGIONS) o.status = STATUS_FULL;
            else begin
               pos = 0;
               while (pos < region_count && region_start[pos] <= s) pos++;
               for (int i = region_count; i > pos; i--) begin
                  region_start[i] = region_start[i-1];
                  region_end[i] = region_end[i-1];
                  region_perm[i] = region_perm[i-1];
               end
               region_start[pos] = s[31:0];
               region_end[pos] = e[31:0];
               region_perm[pos] = r.flags;
               if (hit_valid && hit_index >= pos) hit_index++;
               region_count++;
               o.found = 1;
               o.found_start = s[31:0];
               o.found_end = e[31:0];
               o.found_flags = r.flags;
            end
         end
         KIND_FIND: begin
            idx = region_lookup({32'd0, r.address});
            if (idx >= 0) begin
               o.found = 1;
               o.found_start = region_start[idx];
               o.found_end = region_end[idx];
               o.found_flags = region_perm[idx];
            end
         end
         KIND_CHECK: o.allowed = range_allowed({32'd0, r.address}, {32'd0, r.length},
                                               r.write_access);
         default: begin
            region_count = 0;
            hit_index = 0;
            hit_valid = 0;
         end
      endcase
      o.region_total = region_count[4:0];
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch in %s: got %h, expected %h", what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         window_base <= 32'h0020_0000;
         window_top <= 32'hB000_0000;
         region_count = 0;
         hit_index = 0;
         hit_valid = 0;
         expected_results.delete();
         fail_count = 0;
      end else begin
         if (cfg_write) begin
            if (cfg_addr[2] == REG_USER_TOP) window_top <= cfg_wdata;
            else window_base <= cfg_wdata;
         end
         if (req_valid && !req_stall) expected_results.push_back(predict_item(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("result item with no expectation waiting");
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.status != want.status)
                  report_mismatch("status", rsp_data.status, want.status);
               if (rsp_data.allowed != want.allowed)
                  report_mismatch("allowed", rsp_data.allowed, want.allowed);
               if (rsp_data.found != want.found)
                  report_mismatch("found", rsp_data.found, want.found);
               if (rsp_data.found_start != want.found_start)
                  report_mismatch("found_start", rsp_data.found_start, want.found_start);
               if (rsp_data.found_end != want.found_end)
                  report_mismatch("found_end", rsp_data.found_end, want.found_end);
               if (rsp_data.found_flags != want.found_flags)
                  report_mismatch("found_flags", rsp_data.found_flags, want.found_flags);
               if (rsp_data.region_total != want.region_total)
                  report_mismatch("region_total", rsp_data.region_total, want.region_total);
            end
         end
      end
   end
endmodule

// ===== bench/memory_region_table_core_tb.sv =====
// Testbench top for the region table: stimulus, register setup and verdict.
module memory_region_table_core_tb;
   import mrt_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int HOLD_CYCLES = 400;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;
   int          fail_count;
   int          pending_count;
   int          cycle_count;
   bit          hold_off;

   // Current window, mirrored here so random ranges aim inside it.
   logic [31:0] win_base;
   logic [31:0] win_top;

   memory_region_table_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // The checker sees a register write at the same edge the block takes it.
   memory_region_table_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .cfg_write(psel && penable && pwrite && pready), .cfg_addr(paddr),
      .cfg_wdata(pwdata), .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[memory_region_table_core] ERROR");
         $finish;
      end
   end

   // Receiver: often no stall, else mostly short random stalls, now and then a long one. When
   // hold_off is raised it stalls solidly for a counted stretch so the block
   // backs up, then drops hold_off itself.
   initial begin
      int n;
      rsp_stall = 1;
      @(posedge clock iff !reset);
      forever begin
         if (hold_off) begin
            rsp_stall <= 1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off = 0;
         end else begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) :
                ($urandom_range(0, 2) == 0 ? $urandom_range(1, 4) : 0);
            if (n > 0) begin
               rsp_stall <= 1;
               repeat (n) @(posedge clock);
            end
            rsp_stall <= 0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   // One register write: setup phase, then access phase.
   task automatic write_register(reg_type idx, logic [31:0] value);
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      if (idx == REG_USER_BASE) win_base = value;
      else win_top = value;
   endtask

   // Offer one item and hold it until the block takes it.
   task automatic send_item(req_type r, bit allow_gap);
      int gap;
      if (allow_gap) begin
         gap = ($urandom_range(0, 14) == 0) ? $urandom_range(10, 60) :
               ($urandom_range(0, 1) ? $urandom_range(1, 3) : 0);
         if (gap > 0) begin
            req_valid <= 0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      // With every result taken the sequencer is idle before the CSRs are
      // touched.
      repeat (4) @(posedge clock);
   endtask

   function automatic req_type make_item(kind_type k, logic [31:0] a, logic [31:0] len,
                                         logic [3:0] fl, bit wr);
      req_type r;
      r.kind = k;
      r.address = a;
      r.length = len;
      r.flags = fl;
      r.write_access = wr;
      return r;
   endfunction

   // Random item: mostly maps, finds and checks aimed at the low part of
   // the window so regions collide and sit next to each other; some noise.
   function automatic req_type random_item();
      req_type r;
      int pick;
      logic [31:0] a;
      pick = $urandom_range(0, 99);
      a = win_base + ($urandom_range(0, 63) << 12) + $urandom_range(0, 4095);
      if (pick < 3) a = $urandom();
      r = make_item(KIND_MAP, a, $urandom_range(1, 3 * 4096), $urandom_range(0, 15),
                    $urandom_range(0, 1));
      if (pick >= 97) r.length = $urandom();
      else if (pick >= 95) r.length = 0;
      if (pick < 35) r.kind = KIND_MAP;
      else if (pick < 60) r.kind = KIND_FIND;
      else if (pick < 97) begin
         r.kind = KIND_CHECK;
         r.length = $urandom_range(0, 6 * 4096);
      end else r.kind = KIND_CLEAR;
      return r;
   endfunction

   initial begin
      req_type r;
      reset = 1;
      req_valid = 0;
      req_data = '0;
      psel = 0;
      penable = 0;
      pwrite = 0;
      paddr = '0;
      pwdata = '0;
      cycle_count = 0;
      hold_off = 0;
      win_base = 32'h0020_0000;
      win_top = 32'hB000_0000;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part with the reset window.
      send_item(make_item(KIND_FIND, 32'h0030_0000, 0, 0, 0), 0);
      send_item(make_item(KIND_MAP, 32'h0010_0000, 32'h1000, 4'hF, 0), 0);
      send_item(make_item(KIND_MAP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 1), 0);
      send_item(make_item(KIND_MAP, 32'h0030_0000, 0, 4'h3, 0), 0);
      send_item(make_item(KIND_MAP, 32'h0030_0123, 32'h2000, 4'b1011, 0), 0);
      send_item(make_item(KIND_MAP, 32'h0020_0000, 32'h1000, 4'b0101, 0), 0);
      send_item(make_item(KIND_MAP, 32'h0030_1000, 32'h10, 4'h3, 0), 0);
      send_item(make_item(KIND_MAP, 32'h0030_3000, 32'h1000, 4'b0011, 0), 0);
      send_item(make_item(KIND_MAP, 32'hAFFF_F000, 32'h1000, 4'h0, 0), 0);
      send_item(make_item(KIND_FIND, 32'h0030_2FFF, 0, 0, 0), 0);
      send_item(make_item(KIND_FIND, 32'h0020_0FFF, 0, 0, 0), 0);
      send_item(make_item(KIND_CHECK, 32'h0030_0000, 32'h4000, 4'h0, 0), 0);
      send_item(make_item(KIND_CHECK, 32'h0030_0000, 32'h4000, 4'h0, 1), 0);
      send_item(make_item(KIND_CHECK, 32'h0030_1000, 32'h3000, 4'h0, 1), 0);
      send_item(make_item(KIND_CHECK, 32'h0020_0000, 32'h10, 4'h0, 1), 0);
      send_item(make_item(KIND_CHECK, 32'h0030_0000, 0, 4'h0, 0), 0);
      send_item(make_item(KIND_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'h0, 0), 0);
      send_item(make_item(KIND_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 1), 0);
      // Fill the table to hit the full status.
      for (int i = 0; i < 17; i++)
         send_item(make_item(KIND_MAP, 32'h0040_0000 - i * 32'h2000, 32'h1000,
                             4'h1, 0), 1);
      drain();

      // Random phases over several windows, extremes among them.
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin
               write_register(REG_USER_BASE, 32'h0000_0000);
               write_register(REG_USER_TOP, 32'hFFFF_FFFF);
            end
            1: begin
               write_register(REG_USER_BASE, 32'hFFFF_0000);
               write_register(REG_USER_TOP, 32'hFFFF_FFFF);
            end
            2: begin
               write_register(REG_USER_BASE, 32'h1000_0000);
               write_register(REG_USER_TOP, 32'h1002_0000);
            end
            3: begin
               write_register(REG_USER_BASE, 32'hFFFF_FFFF);
               write_register(REG_USER_TOP, 32'h0000_0000);
            end
            default: begin
               write_register(REG_USER_BASE, 32'h0020_0000);
               write_register(REG_USER_TOP, 32'hB000_0000);
            end
         endcase
         send_item(make_item(KIND_CLEAR, 0, 0, 0, 0), 0);
         if (phase == 4) hold_off = 1;
         for (int i = 0; i < 180; i++) begin
            send_item(random_item(), !(phase == 4 && i < 12));
         end
         drain();
      end

      if (fail_count == 0) $display("[memory_region_table_core] OK");
      else $display("[memory_region_table_core] ERROR");
      $finish;
   end
endmodule
